// ----- hdl/ics_pkg.sv -----
// Shared types and constants for the image colour statistics block.
package ics_pkg;

    localparam int MAX_PIXEL_BITS_DEF = 24;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int FRAC_MAX           = 20;
    localparam int SQRT_W             = 54;

    localparam int GRAY_R = 299;
    localparam int GRAY_G = 587;
    localparam int GRAY_B = 114;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [15:0] mean_red;
        logic [15:0] mean_green;
        logic [15:0] mean_blue;
        logic [15:0] brightness;
        logic [15:0] mean_hue;
        logic [15:0] mean_saturation;
        logic [15:0] colorfulness;
        logic [15:0] contrast;
        logic        count_overflow;
    } result_t;

    // classified pixel handed from the front part to the back part
    typedef struct packed {
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [FRAC_MAX-1:0] hue;
        logic [FRAC_MAX-1:0] sat;
        logic                last;
    } item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SAT,
        F_HUE,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        P_ACC,
        P_DIV,
        P_MUL,
        P_SUB,
        P_SQRT,
        P_SCALE,
        P_OUT
    } back_state_t;

endpackage

// ----- hdl/ics_pixel_if.sv -----
// Pixel and result channel interfaces.
interface ics_pixel_if;
    import ics_pkg::*;
    logic   valid;
    logic   ready;
    pixel_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ics_result_if;
    import ics_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/ics_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ics_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // the numerator register turns into the quotient as bits shift out
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;
endmodule

// ----- hdl/ics_sqrt.sv -----
// Floor square root, one result bit per cycle.
module ics_sqrt #(
    parameter int W = 54
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   val,
    output logic           done,
    output logic [W/2-1:0] root
);
    localparam int STEPS = W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     val_reg;
    logic [W-1:0]     res_reg;
    logic [W-1:0]     bit_reg;
    logic [W-1:0]     trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            val_reg <= val;
            res_reg <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            if (val_reg >= trial)
            begin
                val_reg <= val_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[W/2-1:0];
endmodule

// ----- hdl/ics_queue.sv -----
// Two-entry item queue between the front and back parts.
module ics_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ics_pkg::item_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ics_pkg::item_t pop_data
);
    import ics_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = fill_reg != 2'd2;
    assign pop_valid  = fill_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push_fire} - {1'b0, pop_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- hdl/ics_front.sv -----
// Front part: takes a pixel and works out its HSV hue and saturation.
module ics_front #(
    parameter int FRACTION_BITS = ics_pkg::FRACTION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ics_pixel_if.sink      pixel,
    output logic           push_valid,
    input  logic           push_ready,
    output ics_pkg::item_t push_data
);
    import ics_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int NUM_W = F + 12;
    localparam int DEN_W = 12;
    localparam logic [NUM_W-1:0] ONE_M1 = NUM_W'((1 << F) - 1);

    front_state_t state_reg, state_next;
    logic         started_reg, started_next;
    logic         div_start;
    logic         div_done;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quo;

    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        last_reg;
    logic [7:0]  cmax_reg, delta_reg;
    logic [10:0] hnum_reg;
    logic [FRAC_MAX-1:0] hue_reg, sat_reg;

    logic [7:0]         cmax, cmin, delta;
    logic signed [12:0] hnum;
    logic               accept;

    assign accept = pixel.valid && pixel.ready;

    always_comb
    begin
        cmax = pixel.data.red;
        cmin = pixel.data.red;
        if (pixel.data.green > cmax) cmax = pixel.data.green;
        if (pixel.data.blue > cmax)  cmax = pixel.data.blue;
        if (pixel.data.green < cmin) cmin = pixel.data.green;
        if (pixel.data.blue < cmin)  cmin = pixel.data.blue;
        delta = cmax - cmin;
        // red wins ties for the maximum, then green
        if (cmax == pixel.data.red)
        begin
            hnum = $signed({5'b0, pixel.data.green}) - $signed({5'b0, pixel.data.blue});
            if (hnum < 0)
            begin
                hnum = hnum + $signed(13'(delta) * 13'd6);
            end
        end
        else if (cmax == pixel.data.green)
        begin
            hnum = $signed({5'b0, pixel.data.blue}) - $signed({5'b0, pixel.data.red})
                 + $signed(13'(delta) * 13'd2);
        end
        else
        begin
            hnum = $signed({5'b0, pixel.data.red}) - $signed({5'b0, pixel.data.green})
                 + $signed(13'(delta) * 13'd4);
        end
    end

    always_comb
    begin
        if (state_reg == F_SAT)
        begin
            div_num = (NUM_W'(delta_reg) << (F + 1)) + NUM_W'(cmax_reg);
            div_den = {3'b0, cmax_reg, 1'b0};
        end
        else
        begin
            div_num = (NUM_W'(hnum_reg) << (F + 1)) + NUM_W'(delta_reg) * NUM_W'(6);
            div_den = DEN_W'(delta_reg) * DEN_W'(12);
        end
    end

    ics_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        div_start    = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (pixel.valid)
                begin
                    state_next = F_SAT;
                end
            end
            F_SAT:
            begin
                if (cmax_reg == 8'd0)
                begin
                    state_next = F_HUE;
                end
                else if (!started_reg)
                begin
                    div_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (div_done)
                begin
                    started_next = 1'b0;
                    state_next   = F_HUE;
                end
            end
            F_HUE:
            begin
                if (delta_reg == 8'd0)
                begin
                    state_next = F_PUSH;
                end
                else if (!started_reg)
                begin
                    div_start    = 1'b1;
                    started_next = 1'b1;
                end
                else if (div_done)
                begin
                    started_next = 1'b0;
                    state_next   = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= pixel.data.red;
            green_reg <= pixel.data.green;
            blue_reg  <= pixel.data.blue;
            last_reg  <= pixel.data.last_pixel;
            cmax_reg  <= cmax;
            delta_reg <= delta;
            hnum_reg  <= hnum[10:0];
        end
        if (state_reg == F_SAT)
        begin
            if (cmax_reg == 8'd0)
            begin
                sat_reg <= '0;
            end
            else if (started_reg && div_done)
            begin
                sat_reg <= (div_quo > ONE_M1) ? FRAC_MAX'(ONE_M1) : FRAC_MAX'(div_quo);
            end
        end
        if (state_reg == F_HUE)
        begin
            if (delta_reg == 8'd0)
            begin
                hue_reg <= '0;
            end
            else if (started_reg && div_done)
            begin
                hue_reg <= FRAC_MAX'(div_quo[F-1:0]);  // wraps a full turn to zero
            end
        end
    end

    assign pixel.ready          = state_reg == F_IDLE;
    assign push_valid           = state_reg == F_PUSH;
    assign push_data.red        = red_reg;
    assign push_data.green      = green_reg;
    assign push_data.blue       = blue_reg;
    assign push_data.hue        = hue_reg;
    assign push_data.sat        = sat_reg;
    assign push_data.last       = last_reg;
endmodule

// ----- hdl/ics_back.sv -----
// Back part: accumulates sums and works out the image statistics.
module ics_back #(
    parameter int MAX_PIXEL_BITS = ics_pkg::MAX_PIXEL_BITS_DEF,
    parameter int FRACTION_BITS  = ics_pkg::FRACTION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  ics_pkg::item_t pop_data,
    ics_result_if.source   result
);
    import ics_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int CW     = MAX_PIXEL_BITS + 1;
    localparam int SUM_W  = 8 + CW;
    localparam int HS_W   = F + CW;
    localparam int RG_W   = 9 + CW;
    localparam int YB_W   = 10 + CW;
    localparam int RG2_W  = 16 + CW;
    localparam int YB2_W  = 18 + CW;
    localparam int GR_W   = 18 + CW;
    localparam int GR2_W  = 36 + CW;
    localparam int NUM_W  = 52 + CW;
    localparam int DEN_W  = (11 + CW > 27) ? 11 + CW : 27;
    localparam int ROOT_W = SQRT_W / 2;
    localparam logic [NUM_W-1:0] OUT_MAX =
        (F >= 16) ? NUM_W'(16'hFFFF) : NUM_W'((1 << F) - 1);

    // division steps
    localparam logic [3:0] D_RED   = 4'd0;
    localparam logic [3:0] D_GREEN = 4'd1;
    localparam logic [3:0] D_BLUE  = 4'd2;
    localparam logic [3:0] D_BRIGHT = 4'd3;
    localparam logic [3:0] D_HUE   = 4'd4;
    localparam logic [3:0] D_SAT   = 4'd5;
    localparam logic [3:0] D_ERG   = 4'd6;
    localparam logic [3:0] D_MRG   = 4'd7;
    localparam logic [3:0] D_EYB   = 4'd8;
    localparam logic [3:0] D_MYB   = 4'd9;
    localparam logic [3:0] D_EG    = 4'd10;
    localparam logic [3:0] D_MG    = 4'd11;
    localparam logic [3:0] D_COLOR = 4'd12;
    localparam logic [3:0] D_CONTR = 4'd13;
    localparam logic [3:0] LAST_OP = 4'd2;
    localparam logic [3:0] SCALE_LAST = 4'd1;

    // colorfulness: /1024000 = >>13 then /125; contrast: /130560000 = >>12 then /31875
    localparam logic [22:0] COL_LIM   = 23'd8192000;
    localparam logic [23:0] COL_RECIP = 24'd8589935;
    localparam logic [30:0] CON_LIM   = 31'd2088960000;
    localparam logic [31:0] CON_RECIP = 32'd2207646877;

    back_state_t state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic        run_reg, run_next;

    logic [CW-1:0]           count_reg;
    logic                    ovf_reg;
    logic [SUM_W-1:0]        sr_reg, sg_reg, sb_reg;
    logic [HS_W-1:0]         sh_reg, ss_reg;
    logic signed [RG_W-1:0]  srg_reg;
    logic signed [YB_W-1:0]  syb_reg;
    logic [RG2_W-1:0]        srg2_reg;
    logic [YB2_W-1:0]        syb2_reg;
    logic [GR_W-1:0]         sgr_reg;
    logic [GR2_W-1:0]        sgr2_reg;

    logic [NUM_W-1:0]  q_reg [14];
    logic [SQRT_W-1:0] m_reg [3];
    logic [ROOT_W-1:0] root_reg [3];
    logic [SQRT_W-1:0] t_reg, u_reg, gv_reg;

    logic pop_fire;
    logic full;
    logic clear;

    // per-pixel terms
    logic signed [8:0]  rg;
    logic signed [10:0] yb;
    logic [7:0]         rg_mag;
    logic [9:0]         yb_mag;
    logic [17:0]        gray;

    always_comb
    begin
        rg     = $signed({1'b0, pop_data.red}) - $signed({1'b0, pop_data.green});
        yb     = $signed({3'b0, pop_data.red}) + $signed({3'b0, pop_data.green})
               - $signed({2'b0, pop_data.blue, 1'b0});
        rg_mag = rg[8] ? 8'(-rg) : rg[7:0];
        yb_mag = yb[10] ? 10'(-yb) : yb[9:0];
        gray   = 18'(pop_data.red) * 18'(GRAY_R) + 18'(pop_data.green) * 18'(GRAY_G)
               + 18'(pop_data.blue) * 18'(GRAY_B);
    end

    assign pop_fire = pop_valid && pop_ready;
    assign full     = count_reg[CW-1];
    assign clear    = result.valid && result.ready;

    // divider operand selection
    logic [CW-1:0]    n;
    logic [NUM_W-1:0] n_num;
    logic [DEN_W-1:0] n_den;
    logic [RG_W-1:0]  srg_mag;
    logic [YB_W-1:0]  syb_mag;
    logic [31:0]      mix;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_quo;

    always_comb
    begin
        n       = (count_reg == '0) ? CW'(1) : count_reg;
        n_num   = NUM_W'(n);
        n_den   = DEN_W'(n);
        srg_mag = srg_reg[RG_W-1] ? RG_W'(-srg_reg) : RG_W'(srg_reg);
        syb_mag = syb_reg[YB_W-1] ? YB_W'(-syb_reg) : YB_W'(syb_reg);
        mix     = 32'(root_reg[0]) * 32'd10 + 32'(root_reg[1]) * 32'd3;
        div_num = '0;
        div_den = n_den;
        case (idx_reg)
            D_RED:
            begin
                div_num = (NUM_W'(sr_reg) << (F + 1)) + n_num * NUM_W'(255);
                div_den = n_den * DEN_W'(510);
            end
            D_GREEN:
            begin
                div_num = (NUM_W'(sg_reg) << (F + 1)) + n_num * NUM_W'(255);
                div_den = n_den * DEN_W'(510);
            end
            D_BLUE:
            begin
                div_num = (NUM_W'(sb_reg) << (F + 1)) + n_num * NUM_W'(255);
                div_den = n_den * DEN_W'(510);
            end
            D_BRIGHT:
            begin
                div_num = ((NUM_W'(sr_reg) + NUM_W'(sg_reg) + NUM_W'(sb_reg)) << (F + 1))
                        + n_num * NUM_W'(765);
                div_den = n_den * DEN_W'(1530);
            end
            D_HUE:
            begin
                div_num = (NUM_W'(sh_reg) << 1) + n_num;
                div_den = n_den << 1;
            end
            D_SAT:
            begin
                div_num = (NUM_W'(ss_reg) << 1) + n_num;
                div_den = n_den << 1;
            end
            D_ERG:   div_num = NUM_W'(srg2_reg) << 16;
            D_MRG:   div_num = NUM_W'(srg_mag) << 8;
            D_EYB:   div_num = NUM_W'(syb2_reg) << 16;
            D_MYB:   div_num = NUM_W'(syb_mag) << 8;
            D_EG:    div_num = NUM_W'(sgr2_reg) << 16;
            D_MG:    div_num = NUM_W'(sgr_reg) << 8;
            default:
            begin
                div_num = '0;
            end
        endcase
    end

    ics_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // squares of the means, one per cycle
    logic [26:0]       mul_op;
    logic [SQRT_W-1:0] mul_prod;

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    mul_op = q_reg[D_MRG][26:0];
            2'd1:    mul_op = q_reg[D_MYB][26:0];
            default: mul_op = q_reg[D_MG][26:0];
        endcase
        mul_prod = SQRT_W'(mul_op) * SQRT_W'(mul_op);
    end

    logic [SQRT_W-1:0] erg, eyb, eg;
    logic [SQRT_W-1:0] d_rg, d_yb, d_g;

    always_comb
    begin
        erg  = SQRT_W'(q_reg[D_ERG]);
        eyb  = SQRT_W'(q_reg[D_EYB]);
        eg   = SQRT_W'(q_reg[D_EG]);
        d_rg = (erg > m_reg[0]) ? erg - m_reg[0] : '0;
        d_yb = (eyb > m_reg[1]) ? eyb - m_reg[1] : '0;
        d_g  = (eg > m_reg[2]) ? eg - m_reg[2] : '0;
    end

    logic [SQRT_W-1:0] sq_val;
    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    sq_val = t_reg;
            2'd1:    sq_val = u_reg;
            default: sq_val = gv_reg;
        endcase
    end

    ics_sqrt #(
        .W (SQRT_W)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (sq_val),
        .done  (sq_done),
        .root  (sq_root)
    );

    // final scalings: a shift, then a reciprocal multiply once clamped below the limit
    logic [NUM_W-1:0] col_num, con_num, col_shr, con_shr;
    logic [22:0]      col_m_reg;
    logic             col_sat_reg;
    logic [30:0]      con_m_reg;
    logic             con_sat_reg;
    logic [46:0]      col_prod;
    logic [62:0]      con_prod;

    always_comb
    begin
        col_num  = (NUM_W'(mix) << (F + 1)) + NUM_W'(512000);
        con_num  = (NUM_W'(root_reg[2]) << (F + 1)) + NUM_W'(65280000);
        col_shr  = col_num >> 13;
        con_shr  = con_num >> 12;
        col_prod = 47'(col_m_reg) * 47'(COL_RECIP);
        con_prod = 63'(con_m_reg) * 63'(CON_RECIP);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        run_next   = run_reg;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        pop_ready  = 1'b0;
        unique case (state_reg)
            P_ACC:
            begin
                pop_ready = 1'b1;
                if (pop_valid && pop_data.last)
                begin
                    state_next = P_DIV;
                    idx_next   = D_RED;
                    run_next   = 1'b0;
                end
            end
            P_DIV:
            begin
                if (!run_reg)
                begin
                    div_start = 1'b1;
                    run_next  = 1'b1;
                end
                else if (div_done)
                begin
                    run_next = 1'b0;
                    if (idx_reg == D_MG)
                    begin
                        state_next = P_MUL;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            P_MUL:
            begin
                if (idx_reg == LAST_OP)
                begin
                    state_next = P_SUB;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            P_SUB:
            begin
                state_next = P_SQRT;
                idx_next   = '0;
                run_next   = 1'b0;
            end
            P_SQRT:
            begin
                if (!run_reg)
                begin
                    sq_start = 1'b1;
                    run_next = 1'b1;
                end
                else if (sq_done)
                begin
                    run_next = 1'b0;
                    if (idx_reg == LAST_OP)
                    begin
                        state_next = P_SCALE;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            P_SCALE:
            begin
                if (idx_reg == SCALE_LAST)
                begin
                    state_next = P_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            P_OUT:
            begin
                if (result.ready)
                begin
                    state_next = P_ACC;
                end
            end
            default:
            begin
                state_next = P_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_ACC;
            idx_reg   <= '0;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            run_reg   <= run_next;
        end
    end

    // running sums; pixels past the maximum count are dropped and flagged
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sr_reg    <= '0;
            sg_reg    <= '0;
            sb_reg    <= '0;
            sh_reg    <= '0;
            ss_reg    <= '0;
            srg_reg   <= '0;
            syb_reg   <= '0;
            srg2_reg  <= '0;
            syb2_reg  <= '0;
            sgr_reg   <= '0;
            sgr2_reg  <= '0;
        end
        else if (clear)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sr_reg    <= '0;
            sg_reg    <= '0;
            sb_reg    <= '0;
            sh_reg    <= '0;
            ss_reg    <= '0;
            srg_reg   <= '0;
            syb_reg   <= '0;
            srg2_reg  <= '0;
            syb2_reg  <= '0;
            sgr_reg   <= '0;
            sgr2_reg  <= '0;
        end
        else if (pop_fire)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
                sr_reg    <= sr_reg + SUM_W'(pop_data.red);
                sg_reg    <= sg_reg + SUM_W'(pop_data.green);
                sb_reg    <= sb_reg + SUM_W'(pop_data.blue);
                sh_reg    <= sh_reg + HS_W'(pop_data.hue);
                ss_reg    <= ss_reg + HS_W'(pop_data.sat);
                srg_reg   <= srg_reg + RG_W'(rg);
                syb_reg   <= syb_reg + YB_W'(yb);
                srg2_reg  <= srg2_reg + RG2_W'(16'(rg_mag) * 16'(rg_mag));
                syb2_reg  <= syb2_reg + YB2_W'(20'(yb_mag) * 20'(yb_mag));
                sgr_reg   <= sgr_reg + GR_W'(gray);
                sgr2_reg  <= sgr2_reg + GR2_W'(36'(gray) * 36'(gray));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == P_DIV && run_reg && div_done)
        begin
            q_reg[idx_reg] <= div_quo;
        end
        if (state_reg == P_MUL)
        begin
            m_reg[idx_reg[1:0]] <= mul_prod;
        end
        if (state_reg == P_SUB)
        begin
            t_reg  <= (d_rg << 2) + d_yb;
            u_reg  <= (m_reg[0] << 2) + m_reg[1];
            gv_reg <= d_g;
        end
        if (state_reg == P_SQRT && run_reg && sq_done)
        begin
            root_reg[idx_reg[1:0]] <= sq_root;
        end
        if (state_reg == P_SCALE)
        begin
            if (idx_reg == '0)
            begin
                col_sat_reg <= col_shr >= NUM_W'(COL_LIM);
                col_m_reg   <= col_shr[22:0];
                con_sat_reg <= con_shr >= NUM_W'(CON_LIM);
                con_m_reg   <= con_shr[30:0];
            end
            else
            begin
                q_reg[D_COLOR] <= col_sat_reg ? NUM_W'(16'hFFFF) : NUM_W'(col_prod[46:30]);
                q_reg[D_CONTR] <= con_sat_reg ? NUM_W'(16'hFFFF) : NUM_W'(con_prod[62:46]);
            end
        end
    end

    function automatic logic [15:0] sat_out(input logic [NUM_W-1:0] v);
        sat_out = (v > OUT_MAX) ? OUT_MAX[15:0] : v[15:0];
    endfunction

    assign result.valid                = state_reg == P_OUT;
    assign result.data.mean_red        = sat_out(q_reg[D_RED]);
    assign result.data.mean_green      = sat_out(q_reg[D_GREEN]);
    assign result.data.mean_blue       = sat_out(q_reg[D_BLUE]);
    assign result.data.brightness      = sat_out(q_reg[D_BRIGHT]);
    assign result.data.mean_hue        = sat_out(q_reg[D_HUE]);
    assign result.data.mean_saturation = sat_out(q_reg[D_SAT]);
    assign result.data.colorfulness    = sat_out(q_reg[D_COLOR]);
    assign result.data.contrast        = sat_out(q_reg[D_CONTR]);
    assign result.data.count_overflow  = ovf_reg;
endmodule

// ----- hdl/image_color_statistics.sv -----
// Top level of the image colour statistics block.
//
//  channel  dir  payload
//  pixel    in   red, green, blue, last_pixel
//  result   out  means, brightness, hue, saturation, colorfulness, contrast, overflow
//
// A pixel holds the front part while it is accepted, its saturation and its hue pass in turn
// through the one bit-serial divider, and it is handed off to the queue; a pass is skipped
// when its divisor is zero.
// The back part sums each pixel as it pops it. After the last pixel it runs twelve divisions,
// three squarings, three square roots and the scaling of colorfulness and contrast before
// the result shows; pixels queue meanwhile.
// Reset clears all sums; a waiting result holds the back part, then the input once full.
module image_color_statistics #(
    parameter int MAX_PIXEL_BITS = ics_pkg::MAX_PIXEL_BITS_DEF,
    parameter int FRACTION_BITS  = ics_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ics_pixel_if.sink    pixel,
    ics_result_if.source result
);
    import ics_pkg::*;

    logic  push_valid, push_ready;
    item_t push_data;
    logic  pop_valid, pop_ready;
    item_t pop_data;

    ics_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ics_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ics_back #(
        .MAX_PIXEL_BITS (MAX_PIXEL_BITS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );
endmodule
